// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ISB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also runs while reset is high
`define ISB_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/isb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isb_pkg;

   localparam int WORD_W        = 32;
   localparam int DEPTH_DEFAULT = 64;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic ins;
      logic rem;
   } shift_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/isb_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module isb_cell
   import isb_pkg::*;
#(
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  wire logic                clock,
   input  wire shift_ctrl_type      shift,
   input  wire logic [CNT_W-1:0]    pos,
   input  wire logic [CNT_W-1:0]    cnt,
   input  wire logic [WORD_W-1:0]   val,
   input  wire logic [WORD_W-1:0]   left_data,
   input  wire logic [WORD_W-1:0]   right_data,
   input  wire logic [CNT_W-1:0]    rd_idx,
   output logic      [WORD_W-1:0]   data,
   output logic      [WORD_W-1:0]   rd_data
);

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NXT_IDX = CNT_W'(IDX + 1);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (shift.ins && MY_IDX == pos) begin
         data_in = val;
      end else if (shift.ins && MY_IDX > pos && MY_IDX <= cnt) begin
         data_in = left_data;
      end else if (shift.rem && MY_IDX >= pos && NXT_IDX < cnt) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (rd_idx == MY_IDX) ? data_ff : '0;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_sequence_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// indexed sequence buffer: an ordered list of up to DEPTH signed 32-bit words
// req channel: one beat per request (push, pop, insert at position,
//    remove at position, peek last); accepted when req_valid and req_ready
// rsp channel: exactly one beat per request with the word read, the count
//    after the request and a status (ok, empty, full, position out of range)
// storage is a row of cells, one word each; an insert shifts the words from
//    the position up by one and a remove shifts those above it down, all at once
// latency: the response beat is valid the cycle after the request is taken
// throughput: one request per cycle while rsp_ready stays high
// the response sits in an output register; req_ready is low only while that
//    register holds a beat that rsp_ready does not take in the same cycle
// reset clears the count and the response valid flag; words are written before
//    they are ever read, so the cells need no clearing

`include "assert_macros.svh"

module indexed_sequence_buffer
   import isb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic        [OP_W-1:0]     req_operation,
   input  wire logic signed [WORD_W-1:0]   req_value,
   input  wire logic        [CNT_W-1:0]    req_position,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed      [WORD_W-1:0]   rsp_value_out,
   output logic             [CNT_W-1:0]    rsp_count,
   output logic             [STATUS_W-1:0] rsp_status
);

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic                 req_beat;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   shift_ctrl_type       shift;
   logic [CNT_W-1:0]     shift_pos;
   logic [CNT_W-1:0]     rd_idx;
   logic                 rd_en;
   logic [WORD_W-1:0]    rd_word;

   logic [WORD_W-1:0]    cell_q  [DEPTH];
   logic [WORD_W-1:0]    cell_rd [DEPTH];

   assign req_beat  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      shift         = '{ins: 1'b0, rem: 1'b0};
      shift_pos     = req_position;
      rd_idx        = cnt_ff - CNT_W'(1);
      rd_en         = 1'b0;
      cnt_in        = cnt_ff;
      rsp_status_in = ST_OK;
      unique case (req_operation)
         OP_PUSH: begin
            if (cnt_ff == FULL_CNT) begin
               rsp_status_in = ST_FULL;
            end else begin
               shift.ins = 1'b1;
               shift_pos = cnt_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (cnt_ff == '0) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (cnt_ff == FULL_CNT) begin
               rsp_status_in = ST_FULL;
            end else if (req_position > cnt_ff) begin
               rsp_status_in = ST_RANGE;
            end else begin
               shift.ins = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (cnt_ff == '0) begin
               rsp_status_in = ST_EMPTY;
            end else if (req_position >= cnt_ff) begin
               rsp_status_in = ST_RANGE;
            end else begin
               shift.rem = 1'b1;
               rd_idx    = req_position;
               rd_en     = 1'b1;
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         OP_PEEK: begin
            if (cnt_ff == '0) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rd_en = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!req_beat) begin
         shift = '{ins: 1'b0, rem: 1'b0};
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_q[g+1];
      end
      isb_cell #(
         .CNT_W (CNT_W),
         .IDX   (g)
      ) u_cell (
         .clock      (clock),
         .shift      (shift),
         .pos        (shift_pos),
         .cnt        (cnt_ff),
         .val        (req_value),
         .left_data  (left_w),
         .right_data (right_w),
         .rd_idx     (rd_idx),
         .data       (cell_q[g]),
         .rd_data    (cell_rd[g])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   assign rsp_value_in = rd_en ? rd_word : '0;
   assign rsp_valid_in = req_beat || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_beat) begin
            cnt_ff <= cnt_in;
         end
      end
      if (req_beat) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= cnt_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

   `ISB_ASSERT(a_cnt_bound, cnt_ff <= FULL_CNT, "entry count above depth")
   `ISB_ASSERT(a_push_grows, req_beat && req_operation == OP_PUSH && cnt_ff != FULL_CNT |=> cnt_ff == $past(cnt_ff) + CNT_W'(1), "push did not grow count")
   `ISB_ASSERT(a_err_zero, rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0, "error beat carries a word")
   `ISB_ASSERT(a_cnt_match, rsp_valid_ff && $past(req_beat) |-> rsp_count_ff == cnt_ff, "response count differs from state")
   `ISB_ASSERT_RST(a_reset, reset |=> cnt_ff == '0 && !rsp_valid_ff, "reset did not clear state")

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import isb_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 100;

   localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;
   localparam logic signed [WORD_W-1:0] WORD_ONES = 32'shffffffff;
   localparam logic [CNT_W-1:0] POS_TOP = '1;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic [CNT_W-1:0]         count;
      logic [STATUS_W-1:0]      status;
   } rsp_beat_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] val;
      logic [CNT_W-1:0]         pos;
      logic                     typed;
      rsp_beat_type             want;
   } req_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_operation = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic [CNT_W-1:0] req_position = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_value_out;
   logic [CNT_W-1:0] rsp_count;
   logic [STATUS_W-1:0] rsp_status;

   logic signed [WORD_W-1:0] shadow_words [LIST_DEPTH];
   int shadow_len = 0;
   rsp_beat_type pending_results [$];
   rsp_beat_type oldest_result;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   req_row_type dir_rows [22];

   indexed_sequence_buffer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic apply_list_op(input logic [OP_W-1:0] op,
                                input logic signed [WORD_W-1:0] val,
                                input logic [CNT_W-1:0] pos,
                                output rsp_beat_type r);
      int i;
      int p;
      p = int'(pos);
      r.word = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (shadow_len >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_words[shadow_len] = val;
               shadow_len++;
            end
         end
         OP_POP: begin
            if (shadow_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_len--;
               r.word = shadow_words[shadow_len];
            end
         end
         OP_INSERT: begin
            if (shadow_len >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (p > shadow_len) begin
               r.status = ST_RANGE;
            end else begin
               for (i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[p] = val;
               shadow_len++;
            end
         end
         OP_REMOVE: begin
            if (shadow_len == 0) begin
               r.status = ST_EMPTY;
            end else if (p >= shadow_len) begin
               r.status = ST_RANGE;
            end else begin
               r.word = shadow_words[p];
               for (i = p; i < shadow_len - 1; i++) shadow_words[i] = shadow_words[i+1];
               shadow_len--;
            end
         end
         OP_PEEK: begin
            if (shadow_len == 0) r.status = ST_EMPTY;
            else r.word = shadow_words[shadow_len-1];
         end
         default: ;
      endcase
      r.count = shadow_len[CNT_W-1:0];
   endtask

   task automatic send_request(input req_row_type row);
      rsp_beat_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= row.op;
      req_value <= row.val;
      req_position <= row.pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_list_op(row.op, row.val, row.pos, predicted);
      pending_results.push_back(row.typed ? row.want : predicted);
   endtask

   task automatic pick_random_row(input bit grow, output req_row_type row);
      int mode;
      int pick;
      row = '0;
      row.val = $urandom;
      if ($urandom_range(0, 15) == 0) row.val = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
         row.op = OP_W'($urandom_range(0, (1 << OP_W) - 1));
         row.pos = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
      end else if ($urandom_range(0, 99) < (grow ? 90 : 10)) begin
         row.op = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
         row.pos = CNT_W'($urandom_range(0, shadow_len));
      end else begin
         pick = $urandom_range(0, 4);
         row.op = (pick < 2) ? OP_POP : (pick < 4) ? OP_REMOVE : OP_PEEK;
         row.pos = (shadow_len > 0) ? CNT_W'($urandom_range(0, shadow_len - 1)) : '0;
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("unexpected beat", rsp_value_out, '0);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_value_out !== oldest_result.word)
               flag_mismatch("value_out", rsp_value_out, oldest_result.word);
            if (rsp_count !== oldest_result.count)
               flag_mismatch("count", WORD_W'(rsp_count), WORD_W'(oldest_result.count));
            if (rsp_status !== oldest_result.status)
               flag_mismatch("status", WORD_W'(rsp_status), WORD_W'(oldest_result.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int ph;
      int n;
      req_row_type row;
      dir_rows = '{
         '{OP_POP,       32'sd0,       7'd0,    1'b1, '{32'sd0, 7'd0, ST_EMPTY}},
         '{OP_PEEK,      32'sd0,       7'd0,    1'b1, '{32'sd0, 7'd0, ST_EMPTY}},
         '{OP_REMOVE,    32'sd0,       7'd0,    1'b1, '{32'sd0, 7'd0, ST_EMPTY}},
         '{OP_INSERT,    32'sd5,       7'd1,    1'b1, '{32'sd0, 7'd0, ST_RANGE}},
         '{OP_INSERT,    WORD_MAX,     7'd0,    1'b1, '{32'sd0, 7'd1, ST_OK}},
         '{OP_PUSH,      WORD_MIN,     7'd0,    1'b1, '{32'sd0, 7'd2, ST_OK}},
         '{OP_PEEK,      32'sd0,       7'd0,    1'b1, '{WORD_MIN, 7'd2, ST_OK}},
         '{OP_INSERT,    WORD_ONES,    7'd0,    1'b0, '0},
         '{OP_INSERT,    32'sh5a5a5a5a, 7'd3,   1'b0, '0},
         '{OP_INSERT,    32'sd1,       POS_TOP, 1'b1, '{32'sd0, 7'd4, ST_RANGE}},
         '{OP_REMOVE,    32'sd0,       POS_TOP, 1'b1, '{32'sd0, 7'd4, ST_RANGE}},
         '{OP_REMOVE,    32'sd0,       7'd4,    1'b1, '{32'sd0, 7'd4, ST_RANGE}},
         '{OP_SPARE_LO,  32'sd3,       7'd2,    1'b1, '{32'sd0, 7'd4, ST_OK}},
         '{OP_SPARE_MID, 32'sd0,       7'd0,    1'b1, '{32'sd0, 7'd4, ST_OK}},
         '{OP_SPARE_HI,  WORD_ONES,    POS_TOP, 1'b1, '{32'sd0, 7'd4, ST_OK}},
         '{OP_REMOVE,    32'sd0,       7'd1,    1'b0, '0},
         '{OP_INSERT,    32'sh12345678, 7'd1,   1'b0, '0},
         '{OP_REMOVE,    32'sd0,       7'd0,    1'b0, '0},
         '{OP_POP,       32'sd0,       7'd0,    1'b0, '0},
         '{OP_POP,       32'sd0,       7'd0,    1'b0, '0},
         '{OP_POP,       32'sd0,       7'd0,    1'b0, '0},
         '{OP_POP,       32'sd0,       7'd0,    1'b1, '{32'sd0, 7'd0, ST_EMPTY}}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) send_request(dir_rows[i]);
      for (ph = 0; ph < 4; ph++) begin
         req_valid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
         send_idle_pct = (ph == 1) ? 54 : (ph == 3) ? 37 : 0;
         recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 37 : 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick_random_row(ph % 2 == 0, row);
            send_request(row);
         end
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
